// File: hdl/sfdc_pkg.sv
package sfdc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CMD_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_COMMAND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE  = 2'd3;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
	localparam logic [CMD_W-1:0]  POWER_COMMAND_RST = 16'h0000;
	localparam logic              CHECK_ENABLE_RST  = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic [CMD_W-1:0]  power_command;
		logic              check_enable;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] power_value;
		logic [CMD_W-1:0]  command_word;
		logic              power_updated;
	} result_t;

endpackage

// File: hdl/serial_frame_deframer_checksum.sv
// serial frame deframer with two's complement checksum
//
// rx channel: rx_valid / rx_stall / rx_byte, one byte of the stream per
// transaction. out channel: out_valid / out_stall with power_value,
// command_word and power_updated, one transaction per frame that passes
// the checksum (or every frame when checking is off).
// cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high, so a write lands on the edge where cfg_valid is high.
// write registers only while the block is idle.
//
// a byte goes into the input register and is parsed from there; the result
// register is loaded with a frame result when its checksum byte is parsed.
// throughput is one byte per cycle while the output is not stalled, set by
// the single parse stage between the two registers.
// reset clears the parser to header hunting, the power register to zero
// and the config registers to their defaults; no result is held.
// while out_stall holds a result, at most one more byte is taken into the
// input register; after that rx_stall rises until the result is taken.
module serial_frame_deframer_checksum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [sfdc_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sfdc_pkg::BYTE_W-1:0]     power_value,
	output logic [sfdc_pkg::CMD_W-1:0]      command_word,
	output logic                            power_updated,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfdc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfdc_pkg::*;

	cfg_t              cfg;
	result_t           res;
	result_t           out_data;
	logic              res_valid;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              proc_en;
	logic              rx_take;

	assign cfg_ready = 1'b1;

	// parse only when a result would have room
	assign proc_en  = valid_s1 && (!out_valid || !out_stall);
	assign rx_stall = valid_s1 && !proc_en;
	assign rx_take  = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take || proc_en) begin
			valid_s1 <= rx_take;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take)
			byte_s1 <= rx_byte;
	end

	sfdc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sfdc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc_en),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	sfdc_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.stall  (out_stall),
		.valid  (out_valid),
		.data   (out_data)
	);

	assign power_value   = out_data.power_value;
	assign command_word  = out_data.command_word;
	assign power_updated = out_data.power_updated;

endmodule

// File: hdl/sfdc_cfg_regs.sv
module sfdc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [sfdc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sfdc_pkg::CFG_DATA_W-1:0] wr_data,
	output sfdc_pkg::cfg_t                cfg
);
	import sfdc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HEADER_FIRST_RST;
			cfg_q.header_second <= HEADER_SECOND_RST;
			cfg_q.power_command <= POWER_COMMAND_RST;
			cfg_q.check_enable  <= CHECK_ENABLE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_HEADER_FIRST:  cfg_q.header_first  <= wr_data[BYTE_W-1:0];
				CFG_HEADER_SECOND: cfg_q.header_second <= wr_data[BYTE_W-1:0];
				CFG_POWER_COMMAND: cfg_q.power_command <= wr_data[CMD_W-1:0];
				CFG_CHECK_ENABLE:  cfg_q.check_enable  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/sfdc_parser.sv
module sfdc_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [sfdc_pkg::BYTE_W-1:0] rx_byte,
	input  sfdc_pkg::cfg_t            cfg,
	output logic                      res_valid,
	output sfdc_pkg::result_t         res
);
	import sfdc_pkg::*;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;

	localparam logic [8:0] POS_ZERO  = 9'd0;
	localparam logic [8:0] POS_ONE   = 9'd1;
	localparam logic [8:0] POS_TWO   = 9'd2;
	localparam logic [8:0] POS_THREE = 9'd3;
	localparam logic [8:0] POS_FIVE  = 9'd5;

	logic [2:0]        phase_q, phase_n;
	logic [BYTE_W-1:0] left_q, left_n;
	logic [BYTE_W-1:0] sum_q, sum_n;
	logic [BYTE_W-1:0] len_q, len_n;
	logic [BYTE_W-1:0] b3_q, b3_n;
	logic [BYTE_W-1:0] b5_q, b5_n;
	logic              b5_seen_q, b5_seen_n;
	logic [BYTE_W-1:0] power_q, power_n;
	logic [8:0]        pos_q, pos_n;
	logic              hit;
	logic              sum_ok;
	logic [CMD_W-1:0]  cmd;

	always_comb begin
		phase_n   = phase_q;
		left_n    = left_q;
		sum_n     = sum_q;
		len_n     = len_q;
		b3_n      = b3_q;
		b5_n      = b5_q;
		b5_seen_n = b5_seen_q;
		power_n   = power_q;
		pos_n     = pos_q;
		res_valid = 1'b0;
		hit       = 1'b0;
		sum_ok    = 1'b0;
		cmd       = '0;

		// byte capture shared by payload and checksum bytes
		if (phase_q == PH_PAYLOAD || phase_q == PH_CHECK) begin
			if (pos_q == POS_THREE)
				b3_n = rx_byte;
			if (pos_q == POS_FIVE) begin
				b5_n      = rx_byte;
				b5_seen_n = 1'b1;
			end
			pos_n = pos_q + POS_ONE;
		end

		unique case (phase_q)
			PH_SECOND: begin
				if (rx_byte == cfg.header_second) begin
					phase_n = PH_LENGTH;
					pos_n   = POS_TWO;
				end else if (rx_byte == cfg.header_first) begin
					phase_n = PH_SECOND;
					pos_n   = POS_ONE;
				end else begin
					phase_n = PH_HUNT;
					pos_n   = POS_ZERO;
				end
			end
			PH_LENGTH: begin
				len_n     = rx_byte;
				left_n    = rx_byte;
				sum_n     = '0;
				b3_n      = '0;
				b5_n      = '0;
				b5_seen_n = 1'b0;
				pos_n     = POS_THREE;
				phase_n   = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_n  = sum_q + rx_byte;
				left_n = left_q - 8'd1;
				if (left_n == '0)
					phase_n = PH_CHECK;
			end
			PH_CHECK: begin
				phase_n = PH_HUNT;
				pos_n   = POS_ZERO;
				// checksum holds when sum plus checksum wraps to zero
				sum_ok  = (BYTE_W'(sum_q + rx_byte) == '0) || !cfg.check_enable;
				cmd     = {len_q, b3_n};
				hit     = (cmd == cfg.power_command) && b5_seen_n;
				if (sum_ok) begin
					res_valid = 1'b1;
					if (hit)
						power_n = b5_n;
				end
			end
			default: begin
				if (rx_byte == cfg.header_first) begin
					phase_n = PH_SECOND;
					pos_n   = POS_ONE;
				end else begin
					phase_n = PH_HUNT;
					pos_n   = POS_ZERO;
				end
			end
		endcase

		if (!en)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			left_q    <= '0;
			sum_q     <= '0;
			len_q     <= '0;
			b3_q      <= '0;
			b5_q      <= '0;
			b5_seen_q <= 1'b0;
			power_q   <= '0;
			pos_q     <= '0;
		end else if (en) begin
			phase_q   <= phase_n;
			left_q    <= left_n;
			sum_q     <= sum_n;
			len_q     <= len_n;
			b3_q      <= b3_n;
			b5_q      <= b5_n;
			b5_seen_q <= b5_seen_n;
			power_q   <= power_n;
			pos_q     <= pos_n;
		end
	end

	assign res.power_value   = power_n;
	assign res.command_word  = cmd;
	assign res.power_updated = hit;

endmodule

// File: hdl/sfdc_out_reg.sv
module sfdc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sfdc_pkg::result_t res,
	input  logic              stall,
	output logic              valid,
	output sfdc_pkg::result_t data
);
	import sfdc_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= res;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// File: hdl/sfdc_checker.sv
module sfdc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rx_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [sfdc_pkg::BYTE_W-1:0]     power_value,
	input logic [sfdc_pkg::CMD_W-1:0]      command_word,
	input logic                            power_updated,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(power_value)
			&& $stable(command_word) && $stable(power_updated))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// an empty output register never blocks the byte stream
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !rx_stall)
		else $error("input stalled with empty output");

	// config writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind serial_frame_deframer_checksum sfdc_checker u_sfdc_checker (.*);

// File: tb/sv/serial_frame_deframer_checksum_checker.sv
module serial_frame_deframer_checksum_checker
	import sfdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	input  logic                  rx_stall,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [BYTE_W-1:0]     power_value,
	input  logic [CMD_W-1:0]      command_word,
	input  logic                  power_updated,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending_results,
	output int                    mismatch_count
);

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		READ_LENGTH,
		READ_PAYLOAD,
		READ_CHECKSUM
	} parse_phase_t;

	cfg_t              regs;
	parse_phase_t      phase;
	logic [BYTE_W-1:0] payload_left;
	logic [BYTE_W-1:0] payload_sum;
	logic [BYTE_W-1:0] frame_len;
	logic [BYTE_W-1:0] byte_three;
	logic [BYTE_W-1:0] byte_five;
	logic              byte_five_seen;
	logic [BYTE_W-1:0] power_reg;
	logic [8:0]        frame_pos;
	result_t           frame_results_q[$];

	task automatic note_frame_byte(input logic [BYTE_W-1:0] b);
		if (frame_pos == 9'd3)
			byte_three = b;
		if (frame_pos == 9'd5) begin
			byte_five = b;
			byte_five_seen = 1'b1;
		end
		frame_pos = frame_pos + 9'd1;
	endtask

	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		logic [CMD_W-1:0] cmd;
		logic             hit;
		result_t          res;
		case (phase)
			HUNT_SECOND: begin
				if (b == regs.header_second) begin
					phase = READ_LENGTH;
					frame_pos = 9'd2;
				end else if (b == regs.header_first) begin
					phase = HUNT_SECOND;
					frame_pos = 9'd1;
				end else begin
					phase = HUNT_FIRST;
					frame_pos = 9'd0;
				end
			end
			READ_LENGTH: begin
				frame_len = b;
				payload_left = b;
				payload_sum = '0;
				byte_three = '0;
				byte_five = '0;
				byte_five_seen = 1'b0;
				frame_pos = 9'd3;
				phase = (b == '0) ? READ_CHECKSUM : READ_PAYLOAD;
			end
			READ_PAYLOAD: begin
				note_frame_byte(b);
				payload_sum = payload_sum + b;
				payload_left = payload_left - 8'd1;
				if (payload_left == '0)
					phase = READ_CHECKSUM;
			end
			READ_CHECKSUM: begin
				note_frame_byte(b);
				phase = HUNT_FIRST;
				frame_pos = 9'd0;
				if (!regs.check_enable || b == 8'd0 - payload_sum) begin
					cmd = {frame_len, byte_three};
					hit = (cmd == regs.power_command) && byte_five_seen;
					if (hit)
						power_reg = byte_five;
					res.power_value = power_reg;
					res.command_word = cmd;
					res.power_updated = hit;
					frame_results_q = {frame_results_q, res};
				end
			end
			default: begin
				if (b == regs.header_first) begin
					phase = HUNT_SECOND;
					frame_pos = 9'd1;
				end else begin
					phase = HUNT_FIRST;
					frame_pos = 9'd0;
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [CMD_W-1:0] want,
			input logic [CMD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (frame_results_q.size() == 0) begin
			$error("unexpected result transaction: power_value %0h command_word %0h %s %0b",
				power_value, command_word, "power_updated", power_updated);
			mismatch_count++;
		end else begin
			want = frame_results_q.pop_front();
			compare_field("power_value", CMD_W'(want.power_value), CMD_W'(power_value));
			compare_field("command_word", want.command_word, command_word);
			compare_field("power_updated", CMD_W'(want.power_updated), CMD_W'(power_updated));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.header_first = HEADER_FIRST_RST;
			regs.header_second = HEADER_SECOND_RST;
			regs.power_command = POWER_COMMAND_RST;
			regs.check_enable = CHECK_ENABLE_RST;
			phase = HUNT_FIRST;
			payload_left = '0;
			payload_sum = '0;
			frame_len = '0;
			byte_three = '0;
			byte_five = '0;
			byte_five_seen = 1'b0;
			power_reg = '0;
			frame_pos = '0;
			frame_results_q.delete();
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEADER_FIRST:  regs.header_first = cfg_data[BYTE_W-1:0];
					CFG_HEADER_SECOND: regs.header_second = cfg_data[BYTE_W-1:0];
					CFG_POWER_COMMAND: regs.power_command = cfg_data[CMD_W-1:0];
					CFG_CHECK_ENABLE:  regs.check_enable = cfg_data[0];
					default: ;
				endcase
			end
			if (rx_valid && !rx_stall)
				parse_byte(rx_byte);
			if (out_valid && !out_stall)
				check_result();
			pending_results = frame_results_q.size();
		end
	end

endmodule

// File: tb/sv/serial_frame_deframer_checksum_test.sv
module serial_frame_deframer_checksum_test;
	import sfdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_BYTES   = 900;

	typedef logic [BYTE_W-1:0] octet_q_t[$];

	typedef enum logic [2:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC,
		STALL_HOLD
	} stall_pattern_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  rx_valid;
	logic                  rx_stall;
	logic [BYTE_W-1:0]     rx_byte;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_W-1:0]     power_value;
	logic [CMD_W-1:0]      command_word;
	logic                  power_updated;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int pending_results;
	int mismatch_count;

	logic [BYTE_W-1:0] cur_first;
	logic [BYTE_W-1:0] cur_second;
	logic [CMD_W-1:0]  cur_command;
	int                burst_left = 0;
	int                bytes_sent = 0;
	int                idle_cycles = 0;
	stall_pattern_t    stall_pattern = STALL_NONE;
	int                stall_left = 0;

	serial_frame_deframer_checksum u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_value  (power_value),
		.command_word (command_word),
		.power_updated(power_updated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	serial_frame_deframer_checksum_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_value    (power_value),
		.command_word   (command_word),
		.power_updated  (power_updated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending_results(pending_results),
		.mismatch_count (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_pattern <= stall_pattern_t'($urandom_range(0, 4));
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_pattern)
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= (stall_left % 3 == 0);
			STALL_HOLD:     out_stall <= 1'b1;
			default:        out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_paced(input logic [BYTE_W-1:0] value);
		if (burst_left == 0) begin
			rx_valid <= 1'b0;
			repeat (($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6))
				@(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		rx_valid <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (rx_stall);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame(input octet_q_t payload, input bit sum_ok);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] tail;
		sum = '0;
		send_paced(cur_first);
		send_paced(cur_second);
		send_paced(BYTE_W'(payload.size()));
		foreach (payload[i]) begin
			send_paced(payload[i]);
			sum = sum + payload[i];
		end
		tail = 8'd0 - sum;
		if (!sum_ok)
			tail = tail ^ BYTE_W'($urandom_range(1, 255));
		send_paced(tail);
	endtask

	task automatic random_frame(input int len, input bit aim, input bit sum_ok);
		octet_q_t payload;
		for (int i = 0; i < len; i++)
			payload = {payload, BYTE_W'($urandom_range(0, 255))};
		if (aim && len > 0)
			payload[0] = cur_command[BYTE_W-1:0];
		send_frame(payload, sum_ok);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
			input logic [CMD_W-1:0] command, input logic enable);
		rx_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(CFG_HEADER_FIRST, {8'($urandom), first});
		write_register(CFG_HEADER_SECOND, {8'($urandom), second});
		write_register(CFG_POWER_COMMAND, command);
		write_register(CFG_CHECK_ENABLE, {15'($urandom), enable});
		cfg_valid <= 1'b0;
		cur_first = first;
		cur_second = second;
		cur_command = command;
		burst_left = 0;
	endtask

	task automatic traffic(input int amount);
		int                goal;
		int                pick;
		int                len;
		logic [BYTE_W-1:0] b;
		goal = bytes_sent + amount;
		while (bytes_sent < goal) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(0, 99);
			len = (len < 72) ? $urandom_range(0, 7)
				: (len < 97) ? $urandom_range(8, 40) : $urandom_range(41, 255);
			if (pick < 60) begin
				random_frame(len, $urandom_range(0, 2) == 0, 1'b1);
			end else if (pick < 72) begin
				random_frame(int'(cur_command[CMD_W-1:BYTE_W]), 1'b1, 1'b1);
			end else if (pick < 82) begin
				random_frame(len, $urandom_range(0, 1) != 0, 1'b0);
			end else if (pick < 90) begin
				// broken header
				send_paced(cur_first);
				do b = BYTE_W'($urandom_range(0, 255)); while (b == cur_second);
				send_paced(b);
			end else begin
				repeat ($urandom_range(1, 4)) send_paced(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		octet_q_t          payload;
		rx_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEADER_FIRST;
		cfg_data = '0;
		cur_first = HEADER_FIRST_RST;
		cur_second = HEADER_SECOND_RST;
		cur_command = POWER_COMMAND_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// broken header, repeated first header byte, then zero length
		send_paced(cur_first);
		send_paced(8'h13);
		send_paced(cur_first);
		random_frame(0, 1'b0, 1'b1);
		// header values as payload, byte five is the checksum
		payload = '{8'hAA, 8'h55};
		send_frame(payload, 1'b1);
		payload = '{8'hFF};
		send_frame(payload, 1'b0);

		reconfigure(HEADER_FIRST_RST, HEADER_SECOND_RST, 16'h0200, 1'b1);
		payload = '{8'h00, 8'h7F};
		send_frame(payload, 1'b1);

		reconfigure(8'h00, 8'hFF, 16'h0000, 1'b1);
		traffic(150);
		reconfigure(8'hFF, 8'h00, 16'hFFFF, 1'b0);
		random_frame(255, 1'b1, 1'b1);
		traffic(100);
		while (bytes_sent < RANDOM_BYTES) begin
			first = BYTE_W'($urandom_range(0, 255));
			second = ($urandom_range(0, 4) == 0) ? first : BYTE_W'($urandom_range(0, 255));
			reconfigure(first, second,
				{8'($urandom_range(0, 8)), 8'($urandom_range(0, 255))},
				$urandom_range(0, 3) != 0);
			traffic(150);
		end

		rx_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
